// ----- design/kst_pkg.sv -----
// kst_pkg: shared types and constants for the keyed slot table.
// Depends on nothing; imported by every module of the block but kst_ram.
package kst_pkg;

  localparam int KEY_W  = 40;   // one key half
  localparam int POS_W  = 4;    // row / col field
  localparam int SIZE_W = 5;    // size registers
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;

  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OCCUPIED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic              load;       // capture input beat, rewind scan
    logic              clr_step;   // clear one slot of the table
    logic              ins_rd;     // read slot at insert position
    logic              ins_write;  // store key, mark slot
    logic              scan_issue; // read slot at scan position, advance
    logic              scan_free;  // free slot of the pending compare
    logic              set_res;    // stage a result
    logic [STAT_W-1:0] res_code;
    logic              res_occ;    // staged result carries read key
    logic              push;       // staged result -> output register
  } kst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic pos_ok;
    logic scan_empty;
    logic scan_last;
    logic slot_taken;
    logic key_match;
    logic clr_last;
  } kst_sts_t;

endpackage

// ----- design/kst_ram.sv -----
// kst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/kst_dp.sv -----
// kst_dp: datapath of the keyed slot table: size registers, captured beat,
// scan and clear counters, slot RAM, result registers. Uses kst_pkg, kst_ram.
module kst_dp import kst_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  input  logic                 in_action,
  input  logic [POS_W-1:0]     in_row,
  input  logic [POS_W-1:0]     in_col,
  input  logic [KEY_W-1:0]     in_key_high,
  input  logic [KEY_W-1:0]     in_key_low,
  output logic [STAT_W-1:0]    out_status,
  output logic [KEY_W-1:0]     out_occupant_high,
  output logic [KEY_W-1:0]     out_occupant_low,
  input  kst_cmd_t             cmd,
  output kst_sts_t             sts
);

  localparam int SLOTS   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ENTRY_W = 2 * KEY_W + 1;
  // saturation bound for the size registers (they never exceed 31)
  localparam int ROW_SAT = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
  localparam int COL_SAT = (MAX_COLS > 31) ? 31 : MAX_COLS;

  logic [SIZE_W-1:0] rows_r, rows_nxt;
  logic [SIZE_W-1:0] cols_r, cols_nxt;
  logic [SIZE_W-1:0] eff_rows, eff_cols;

  logic              action_r;
  logic [POS_W-1:0]  row_r, col_r;
  logic [KEY_W-1:0]  key_hi_r, key_lo_r;

  logic [SIZE_W-1:0] scan_row_r, scan_row_nxt;
  logic [SIZE_W-1:0] scan_col_r, scan_col_nxt;
  logic [ADDR_W-1:0] cmp_addr_r;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  logic [ADDR_W-1:0] ins_addr, scan_addr;
  logic              col_last;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic              rd_taken;
  logic [KEY_W-1:0]  rd_key_hi, rd_key_lo;

  logic [STAT_W-1:0] res_status_r;
  logic [KEY_W-1:0]  res_hi_r, res_lo_r;
  logic [STAT_W-1:0] out_status_r;
  logic [KEY_W-1:0]  out_hi_r, out_lo_r;

  // ---- size registers ----
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS: rows_nxt = cfg_wdata;
        REG_COLS: cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign eff_rows = (rows_r > SIZE_W'(ROW_SAT)) ? SIZE_W'(ROW_SAT) : rows_r;
  assign eff_cols = (cols_r > SIZE_W'(COL_SAT)) ? SIZE_W'(COL_SAT) : cols_r;

  // ---- addresses ----
  assign ins_addr  = ADDR_W'(int'(row_r) * MAX_COLS + int'(col_r));
  assign scan_addr = ADDR_W'(int'(scan_row_r) * MAX_COLS + int'(scan_col_r));
  assign col_last  = (scan_col_r == eff_cols - SIZE_W'(1));

  always_comb begin
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    clr_nxt      = clr_r;
    if (cmd.load) begin
      scan_row_nxt = '0;
      scan_col_nxt = '0;
    end else if (cmd.scan_issue) begin
      if (col_last) begin
        scan_col_nxt = '0;
        scan_row_nxt = scan_row_r + SIZE_W'(1);
      end else begin
        scan_col_nxt = scan_col_r + SIZE_W'(1);
      end
    end
    if (cmd.clr_step) begin
      clr_nxt = clr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= SIZE_RST;
      cols_r     <= SIZE_RST;
      clr_r      <= '0;
      scan_row_r <= '0;
      scan_col_r <= '0;
    end else begin
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      clr_r      <= clr_nxt;
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
    end
  end

  // ---- captured beat, compare address, results ----
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      row_r    <= in_row;
      col_r    <= in_col;
      key_hi_r <= in_key_high;
      key_lo_r <= in_key_low;
    end
    if (cmd.scan_issue) begin
      cmp_addr_r <= scan_addr;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_hi_r     <= cmd.res_occ ? rd_key_hi : '0;
      res_lo_r     <= cmd.res_occ ? rd_key_lo : '0;
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_hi_r     <= res_hi_r;
      out_lo_r     <= res_lo_r;
    end
  end

  // ---- slot RAM: {taken, key_high, key_low} ----
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd.ins_write) begin
      ram_we    = 1'b1;
      ram_waddr = ins_addr;
      ram_wdata = {1'b1, key_hi_r, key_lo_r};
    end else if (cmd.scan_free) begin
      ram_we    = 1'b1;
      ram_waddr = cmp_addr_r;
    end
  end

  assign ram_re    = cmd.ins_rd | cmd.scan_issue;
  assign ram_raddr = cmd.ins_rd ? ins_addr : scan_addr;

  kst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_taken  = ram_rdata[ENTRY_W-1];
  assign rd_key_hi = ram_rdata[2*KEY_W-1:KEY_W];
  assign rd_key_lo = ram_rdata[KEY_W-1:0];

  // ---- status ----
  always_comb begin
    sts.is_remove  = (action_r == ACT_REMOVE);
    sts.pos_ok     = ({1'b0, row_r} < eff_rows) && ({1'b0, col_r} < eff_cols);
    sts.scan_empty = (eff_rows == '0) || (eff_cols == '0);
    sts.scan_last  = col_last && (scan_row_r == eff_rows - SIZE_W'(1));
    sts.slot_taken = rd_taken;
    sts.key_match  = rd_taken && (rd_key_hi == key_hi_r) && (rd_key_lo == key_lo_r);
    sts.clr_last   = (clr_r == ADDR_W'(SLOTS - 1));
  end

  assign out_status        = out_status_r;
  assign out_occupant_high = out_hi_r;
  assign out_occupant_low  = out_lo_r;

endmodule

// ----- design/kst_ctrl.sv -----
// kst_ctrl: controller state machine of the keyed slot table.
// Uses kst_pkg; drives kst_dp through kst_cmd_t, reads kst_sts_t.
module kst_ctrl import kst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output kst_cmd_t cmd,
  input  kst_sts_t sts
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DEC     = 3'd2;
  localparam logic [2:0] S_INS_CHK = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_TAIL    = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;       // scan compare in flight
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_remove) begin
          if (sts.scan_empty) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOT_FOUND;
            state_nxt    = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (!sts.pos_ok) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_INVALID;
          state_nxt    = S_FIN;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        cmd.set_res = 1'b1;
        if (sts.slot_taken) begin
          cmd.res_code = ST_OCCUPIED;
          cmd.res_occ  = 1'b1;
        end else begin
          cmd.ins_write = 1'b1;
          cmd.res_code  = ST_OK;
        end
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        if (pend_r && sts.key_match) begin
          cmd.scan_free = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_code  = ST_OK;
          state_nxt     = S_FIN;
        end else begin
          cmd.scan_issue = 1'b1;
          pend_nxt       = 1'b1;
          if (sts.scan_last) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        cmd.set_res = 1'b1;
        if (sts.key_match) begin
          cmd.scan_free = 1'b1;
          cmd.res_code  = ST_OK;
        end else begin
          cmd.res_code = ST_NOT_FOUND;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/keyed_slot_table.sv -----
// keyed_slot_table: top level of the keyed slot table (controller + datapath).
// Uses kst_pkg, kst_ctrl, kst_dp (which holds the kst_ram slot store).
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | action, row, col, key_high, key_low
//   out      | out_valid/ out_ready | status, occupant_high, occupant_low
//   cfg      | cfg_we (no wait)     | cfg_addr (0 rows, 1 cols), cfg_wdata
//
// Steps: an insert goes from accept through decode with slot read, check and
// push to the result register; an insert outside the grid skips the check. A
// remove scans up to the slots in use after size saturation, then stages and
// pushes its result; the single read port of the slot RAM scans one slot per
// cycle.
// Reset: rst_n is synchronous. After reset a clearing pass frees every slot,
// with in_ready low; size registers come up at 16.
// Stalls: one result register; the next beat is accepted while a result is
// still waiting, and its own result is held until out_ready frees the register.
module keyed_slot_table import kst_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  // input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [POS_W-1:0]     in_row,
  input  logic [POS_W-1:0]     in_col,
  input  logic [KEY_W-1:0]     in_key_high,
  input  logic [KEY_W-1:0]     in_key_low,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [KEY_W-1:0]     out_occupant_high,
  output logic [KEY_W-1:0]     out_occupant_low
);

  kst_cmd_t cmd;
  kst_sts_t sts;

  // sequencing: clear pass, decode, insert read/check, remove scan
  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // size registers, slot store, key compare, result registers
  kst_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_action),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_key_high       (in_key_high),
    .in_key_low        (in_key_low),
    .out_status        (out_status),
    .out_occupant_high (out_occupant_high),
    .out_occupant_low  (out_occupant_low),
    .cmd               (cmd),
    .sts               (sts)
  );

  // ---- checks ----

  // slot RAM has one write port: at most one writer per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.ins_write, cmd.scan_free}))
    else $error("two writes to the slot RAM in one cycle");

  // no beat is taken while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ready)
    else $error("input ready during clearing pass");

  // a result only enters the output register when that register is free
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result overwrote a pending beat");

  // a beat is decoded first: no result in the cycle after accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !cmd.push)
    else $error("result pushed right after accept");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for keyed_slot_table (insert / remove-by-key slot table).
// Depends on kst_pkg and the keyed_slot_table RTL; needs nothing else.
module testbench import kst_pkg::*; ();

  localparam int TB_ROWS = DEF_MAX_ROWS;
  localparam int TB_COLS = DEF_MAX_COLS;
  localparam int SLOTS   = TB_ROWS * TB_COLS;
  // worst remove scans every slot, plus its decode and push
  localparam int TAIL_CYCLES = SLOTS + 40;
  localparam int REPORT_CAP  = 40;
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

  typedef struct packed {
    logic             action;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [KEY_W-1:0] key_hi;
    logic [KEY_W-1:0] key_lo;
  } table_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  occ_hi;
    logic [KEY_W-1:0]  occ_lo;
  } table_result_t;

  // directed table rows: either one input beat or one register write
  typedef enum logic { ROW_BEAT, ROW_CFG } dir_kind_t;

  typedef struct {
    dir_kind_t           kind;
    table_op_t           op;
    bit                  typed;   // expected result given in the row
    table_result_t       res;
    logic [CFG_IDX_W-1:0] addr;
    logic [SIZE_W-1:0]   data;
  } dir_row_t;

  // DUT ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [SIZE_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = ACT_INSERT;
  logic [POS_W-1:0]     in_row = '0;
  logic [POS_W-1:0]     in_col = '0;
  logic [KEY_W-1:0]     in_key_high = '0;
  logic [KEY_W-1:0]     in_key_low = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [KEY_W-1:0]     out_occupant_high;
  logic [KEY_W-1:0]     out_occupant_low;

  keyed_slot_table DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_key_high      (in_key_high),
    .in_key_low       (in_key_low),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_occupant_high(out_occupant_high),
    .out_occupant_low (out_occupant_low)
  );

  // shadow copy of the table and its size registers
  logic [SIZE_W-1:0] shadow_rows = SIZE_RST;
  logic [SIZE_W-1:0] shadow_cols = SIZE_RST;
  bit               shadow_taken [SLOTS];
  logic [KEY_W-1:0] shadow_key_hi [SLOTS];
  logic [KEY_W-1:0] shadow_key_lo [SLOTS];

  table_result_t pending_results[$];
  dir_row_t      dir_rows[$];
  logic [KEY_W-1:0] key_pool_hi [12];
  logic [KEY_W-1:0] key_pool_lo [12];

  int errors = 0;
  int beats_in = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int status_hits [4];
  int tx_idle_pct = 9;
  int rx_idle_pct = 77;

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #12_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // receiver: out_ready changes on the falling edge only
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic int eff_size(input logic [SIZE_W-1:0] r, input int lim);
    return (r > lim) ? lim : int'(r);
  endfunction

  // Expected result of one table operation; updates the shadow table.
  function automatic table_result_t predict_slot_op(input table_op_t op);
    table_result_t res;
    int nr;
    int nc;
    int idx;
    bit found;
    res = '0;
    nr = eff_size(shadow_rows, TB_ROWS);
    nc = eff_size(shadow_cols, TB_COLS);
    found = 1'b0;
    if (op.action == ACT_INSERT) begin
      if (op.row >= nr || op.col >= nc) begin
        res.status = ST_INVALID;
      end else begin
        idx = op.row * TB_COLS + op.col;
        if (shadow_taken[idx]) begin
          res.status = ST_OCCUPIED;
          res.occ_hi = shadow_key_hi[idx];
          res.occ_lo = shadow_key_lo[idx];
        end else begin
          shadow_taken[idx]  = 1'b1;
          shadow_key_hi[idx] = op.key_hi;
          shadow_key_lo[idx] = op.key_lo;
          res.status = ST_OK;
        end
      end
    end else begin
      // row-major scan of the area in use; free slots never match
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          idx = r * TB_COLS + c;
          if (!found && shadow_taken[idx] && shadow_key_hi[idx] == op.key_hi &&
              shadow_key_lo[idx] == op.key_lo) begin
            shadow_taken[idx] = 1'b0;
            found = 1'b1;
          end
        end
      end
      res.status = found ? ST_OK : ST_NOT_FOUND;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_v,
                             input logic [KEY_W-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      if (errors == REPORT_CAP)
        $display("%0t: further mismatch reports suppressed", $time);
    end
  endtask

  // result monitor: every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, got status %0d",
                 $time, out_status);
      end else begin
        want = pending_results.pop_front();
        status_hits[want.status]++;
        check_field("status", KEY_W'(want.status), KEY_W'(out_status));
        check_field("occupant_high", want.occ_hi, out_occupant_high);
        check_field("occupant_low", want.occ_lo, out_occupant_low);
      end
    end
  end

  // Present one beat from a falling edge, hold it until accepted; returns at a
  // falling edge with in_valid still high.
  task automatic send_beat(input table_op_t op, input bit typed, input table_result_t res);
    table_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= op.action;
    in_row      <= op.row;
    in_col      <= op.col;
    in_key_high <= op.key_hi;
    in_key_low  <= op.key_lo;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    pred = predict_slot_op(op);
    pending_results.push_back(typed ? res : pred);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [SIZE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_ROWS) shadow_rows = data;
    else shadow_cols = data;
    cfg_writes++;
    @(negedge clk);
  endtask

  function automatic void dir_beat(input logic act, input int r, input int c,
                                   input logic [KEY_W-1:0] kh, input logic [KEY_W-1:0] kl,
                                   input bit typed = 1'b0,
                                   input logic [STAT_W-1:0] st = ST_OK,
                                   input logic [KEY_W-1:0] oh = '0,
                                   input logic [KEY_W-1:0] ol = '0);
    dir_row_t d;
    d.kind  = ROW_BEAT;
    d.op    = '{act, POS_W'(r), POS_W'(c), kh, kl};
    d.typed = typed;
    d.res   = '{st, oh, ol};
    d.addr  = '0;
    d.data  = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void dir_cfg(input logic [CFG_IDX_W-1:0] addr, input int data);
    dir_row_t d;
    d.kind  = ROW_CFG;
    d.op    = '0;
    d.typed = 1'b0;
    d.res   = '0;
    d.addr  = addr;
    d.data  = SIZE_W'(data);
    dir_rows.push_back(d);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key;
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[KEY_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size;
    case ($urandom_range(9))
      0: return SIZE_W'($urandom_range(31, 17));   // saturates to the max
      1: return SIZE_W'(1);
      2: return SIZE_W'(16);
      default: return SIZE_W'($urandom_range(16, 1));
    endcase
  endfunction

  // Mostly well-formed traffic: inserts in range, removes of keys that are
  // present; some out-of-range inserts and removes of unknown keys.
  function automatic table_op_t gen_op;
    table_op_t op;
    int nr;
    int nc;
    int pick;
    int k;
    int idx;
    nr = eff_size(shadow_rows, TB_ROWS);
    nc = eff_size(shadow_cols, TB_COLS);
    op.action = ACT_INSERT;
    op.row = POS_W'($urandom);
    op.col = POS_W'($urandom);
    k = $urandom_range(11);
    case ($urandom_range(9))
      0:       begin op.key_hi = rand_key(); op.key_lo = rand_key(); end
      1:       begin op.key_hi = '0;         op.key_lo = '0;         end
      2:       begin op.key_hi = KEY_ONES;   op.key_lo = KEY_ONES;   end
      default: begin op.key_hi = key_pool_hi[k]; op.key_lo = key_pool_lo[k]; end
    endcase
    pick = $urandom_range(99);
    if (pick < 50) begin
      op.row = POS_W'($urandom_range(nr - 1, 0));
      op.col = POS_W'($urandom_range(nc - 1, 0));
    end else if (pick < 60) begin
      if (nr < TB_ROWS && $urandom_range(1)) op.row = POS_W'($urandom_range(TB_ROWS - 1, nr));
      else if (nc < TB_COLS) op.col = POS_W'($urandom_range(TB_COLS - 1, nc));
    end else begin
      op.action = ACT_REMOVE;
      if (pick < 88) begin
        // probe eight slots in use for a key that is really there
        for (int t = 0; t < 8; t++) begin
          idx = $urandom_range(nr - 1, 0) * TB_COLS + $urandom_range(nc - 1, 0);
          if (shadow_taken[idx]) begin
            op.key_hi = shadow_key_hi[idx];
            op.key_lo = shadow_key_lo[idx];
          end
        end
      end
    end
    return op;
  endfunction

  initial begin
    table_result_t none;
    logic [KEY_W-1:0] ka_hi;
    logic [KEY_W-1:0] ka_lo;
    logic [KEY_W-1:0] kb_hi;
    logic [KEY_W-1:0] kb_lo;
    logic [KEY_W-1:0] kc_hi;
    logic [KEY_W-1:0] kc_lo;
    none = '0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_taken[i]  = 1'b0;
      shadow_key_hi[i] = '0;
      shadow_key_lo[i] = '0;
    end
    for (int i = 0; i < 4; i++) status_hits[i] = 0;
    ka_hi = 40'h01_2345_6789; ka_lo = 40'hAB_CDEF_0123;
    kb_hi = 40'hA5_A5A5_A5A5; kb_lo = 40'h5A_5A5A_5A5A;
    kc_hi = 40'h80_0000_0001; kc_lo = 40'h00_0000_0080;

    // --- directed table ---
    // fresh table: remove misses, corners of the grid, occupied reports
    dir_beat(ACT_REMOVE, 0, 0, '0, '0, 1, ST_NOT_FOUND);
    dir_beat(ACT_INSERT, 0, 0, '0, '0, 1, ST_OK);                  // all-zero key is legal
    dir_beat(ACT_INSERT, 15, 15, KEY_ONES, KEY_ONES, 1, ST_OK);
    dir_beat(ACT_INSERT, 0, 0, ka_hi, ka_lo, 1, ST_OCCUPIED, '0, '0);
    dir_beat(ACT_INSERT, 15, 15, '0, '0, 1, ST_OCCUPIED, KEY_ONES, KEY_ONES);
    dir_beat(ACT_REMOVE, 9, 6, KEY_ONES, KEY_ONES, 1, ST_OK);
    dir_beat(ACT_REMOVE, 0, 0, KEY_ONES, KEY_ONES, 1, ST_NOT_FOUND); // freed slot is cleared to zero
    // duplicate key: remove takes the first slot in row-major order
    dir_beat(ACT_INSERT, 15, 15, '0, '0);
    dir_beat(ACT_REMOVE, 3, 3, '0, '0);
    dir_beat(ACT_INSERT, 0, 0, ka_hi, ka_lo);
    dir_beat(ACT_INSERT, 15, 15, kb_hi, kb_lo);
    dir_beat(ACT_INSERT, 7, 9, kb_hi, kb_lo);
    // zero rows: nothing in use
    dir_cfg(REG_ROWS, 0);
    dir_beat(ACT_INSERT, 0, 0, kc_hi, kc_lo, 1, ST_INVALID);
    dir_beat(ACT_REMOVE, 0, 0, ka_hi, ka_lo, 1, ST_NOT_FOUND);
    // oversize registers saturate at the full grid
    dir_cfg(REG_ROWS, 31);
    dir_cfg(REG_COLS, 31);
    dir_beat(ACT_INSERT, 15, 15, kc_hi, kc_lo);
    // shrunk grid: outside slots keep contents but are not scanned
    dir_cfg(REG_ROWS, 2);
    dir_cfg(REG_COLS, 3);
    dir_beat(ACT_INSERT, 2, 0, kc_hi, kc_lo, 1, ST_INVALID);
    dir_beat(ACT_INSERT, 1, 3, kc_hi, kc_lo, 1, ST_INVALID);
    dir_beat(ACT_INSERT, 1, 2, kc_hi, kc_lo);
    dir_beat(ACT_REMOVE, 0, 0, '0, '0);
    dir_cfg(REG_COLS, 0);
    dir_beat(ACT_INSERT, 0, 0, kc_hi, kc_lo, 1, ST_INVALID);
    // smallest real grid
    dir_cfg(REG_ROWS, 1);
    dir_cfg(REG_COLS, 1);
    dir_beat(ACT_INSERT, 0, 0, kb_hi, kb_lo);
    dir_beat(ACT_REMOVE, 0, 0, ka_hi, ka_lo);
    dir_beat(ACT_REMOVE, 0, 0, kc_hi, kc_lo);
    dir_cfg(REG_ROWS, 16);
    dir_cfg(REG_COLS, 16);
    dir_beat(ACT_REMOVE, 0, 0, kc_hi, kc_lo);

    // reset, then release; the clearing pass afterwards shows up
    // as in_ready low
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // --- random part: nine stretches, each with its own grid size ---
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin tx_idle_pct = 77; rx_idle_pct = 9; end
      if (ph == 6) begin tx_idle_pct = 0;  rx_idle_pct = 0; end
      drain_results();
      write_reg(REG_ROWS, rand_size());
      write_reg(REG_COLS, rand_size());
      for (int i = 0; i < 12; i++) begin
        key_pool_hi[i] = rand_key();
        key_pool_lo[i] = rand_key();
      end
      repeat (50) send_beat(gen_op(), 1'b0, none);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("Covered %0d input beats, %0d result beats, %0d register writes.",
             beats_in, results_seen, cfg_writes);
    $display("Statuses seen: ok %0d, occupied %0d, not found %0d, invalid %0d.",
             status_hits[ST_OK], status_hits[ST_OCCUPIED], status_hits[ST_NOT_FOUND],
             status_hits[ST_INVALID]);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
